// ===== rtl/cpt_pkg.sv =====
// package for the closest-point-on-triangle unit: widths, region codes and payload structs
// no dependencies; every rtl file imports it
package cpt_pkg;

    localparam int CoordW = 16;
    localparam int FracW  = 16;
    // edge and offset vectors
    localparam int DiffW  = CoordW + 1;
    // dot products, with headroom for three terms and a sign
    localparam int DotW   = 2 * DiffW + 2;
    // operand split for the wide products
    localparam int SplitW = DotW / 2;
    // det, s0, s1 and every divider operand
    localparam int ProdW  = 2 * DotW;
    // divider remainder: twice the largest denominator
    localparam int DivW   = ProdW + 1;
    localparam int OutW   = FracW + 1;

    localparam logic [OutW-1:0] FxOne = {1'b1, {FracW{1'b0}}};

    typedef enum logic [2:0] {
        REG_INTERIOR = 3'd0,
        REG_EDGE12   = 3'd1,
        REG_V2       = 3'd2,
        REG_EDGE02   = 3'd3,
        REG_V0       = 3'd4,
        REG_EDGE01   = 3'd5,
        REG_V1       = 3'd6
    } t_region;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
        logic signed [CoordW-1:0] v0_x;
        logic signed [CoordW-1:0] v0_y;
        logic signed [CoordW-1:0] v0_z;
        logic signed [CoordW-1:0] v1_x;
        logic signed [CoordW-1:0] v1_y;
        logic signed [CoordW-1:0] v1_z;
        logic signed [CoordW-1:0] v2_x;
        logic signed [CoordW-1:0] v2_y;
        logic signed [CoordW-1:0] v2_z;
    } t_in_item;

    typedef struct packed {
        logic [OutW-1:0] ref_s;
        logic [OutW-1:0] ref_t;
        t_region         region;
        logic            degenerate;
    } t_out_item;

    typedef struct packed {
        logic signed [DotW-1:0] a00;
        logic signed [DotW-1:0] a01;
        logic signed [DotW-1:0] a11;
        logic signed [DotW-1:0] b0;
        logic signed [DotW-1:0] b1;
    } t_dots;

    // one clamped quotient request; inv asks for one minus the quotient
    typedef struct packed {
        logic signed [ProdW-1:0] num;
        logic signed [ProdW-1:0] den;
        logic                    inv;
    } t_lane;

    typedef struct packed {
        t_region region;
        logic    degenerate;
    } t_meta;

endpackage

// ===== rtl/cpt_dot.sv =====
// edge vectors and the five dot products, three register stages
// depends on cpt_pkg
module cpt_dot import cpt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_dots    o_dots
);

    localparam int PrW = 2 * DiffW;

    logic signed [CoordW-1:0] w_p [3];
    logic signed [CoordW-1:0] w_v0[3];
    logic signed [CoordW-1:0] w_v1[3];
    logic signed [CoordW-1:0] w_v2[3];

    logic signed [DiffW-1:0] n_d[3], n_e0[3], n_e1[3];
    logic signed [DiffW-1:0] r_d[3], r_e0[3], r_e1[3];
    logic signed [PrW-1:0]   n_p00[3], n_p01[3], n_p11[3], n_pd0[3], n_pd1[3];
    logic signed [PrW-1:0]   r_p00[3], r_p01[3], r_p11[3], r_pd0[3], r_pd1[3];
    t_dots                   n_dots, r_dots;
    logic [2:0]              r_v;

    assign w_p[0]  = i_item.point_x;
    assign w_p[1]  = i_item.point_y;
    assign w_p[2]  = i_item.point_z;
    assign w_v0[0] = i_item.v0_x;
    assign w_v0[1] = i_item.v0_y;
    assign w_v0[2] = i_item.v0_z;
    assign w_v1[0] = i_item.v1_x;
    assign w_v1[1] = i_item.v1_y;
    assign w_v1[2] = i_item.v1_z;
    assign w_v2[0] = i_item.v2_x;
    assign w_v2[1] = i_item.v2_y;
    assign w_v2[2] = i_item.v2_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_d[k]   = DiffW'(w_p[k])  - DiffW'(w_v0[k]);
            n_e0[k]  = DiffW'(w_v1[k]) - DiffW'(w_v0[k]);
            n_e1[k]  = DiffW'(w_v2[k]) - DiffW'(w_v0[k]);
            n_p00[k] = PrW'(r_e0[k]) * PrW'(r_e0[k]);
            n_p01[k] = PrW'(r_e0[k]) * PrW'(r_e1[k]);
            n_p11[k] = PrW'(r_e1[k]) * PrW'(r_e1[k]);
            n_pd0[k] = PrW'(r_d[k])  * PrW'(r_e0[k]);
            n_pd1[k] = PrW'(r_d[k])  * PrW'(r_e1[k]);
        end
        n_dots.a00 = DotW'(r_p00[0]) + DotW'(r_p00[1]) + DotW'(r_p00[2]);
        n_dots.a01 = DotW'(r_p01[0]) + DotW'(r_p01[1]) + DotW'(r_p01[2]);
        n_dots.a11 = DotW'(r_p11[0]) + DotW'(r_p11[1]) + DotW'(r_p11[2]);
        // b terms are the negated offset projections
        n_dots.b0  = DotW'(0) - DotW'(r_pd0[0]) - DotW'(r_pd0[1]) - DotW'(r_pd0[2]);
        n_dots.b1  = DotW'(0) - DotW'(r_pd1[0]) - DotW'(r_pd1[1]) - DotW'(r_pd1[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k]   <= n_d[k];
                r_e0[k]  <= n_e0[k];
                r_e1[k]  <= n_e1[k];
                r_p00[k] <= n_p00[k];
                r_p01[k] <= n_p01[k];
                r_p11[k] <= n_p11[k];
                r_pd0[k] <= n_pd0[k];
                r_pd1[k] <= n_pd1[k];
            end
            r_dots <= n_dots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_dots  = r_dots;

endmodule

// ===== rtl/cpt_solve.sv =====
// det, s0, s1 from split wide products, region test and divider operand select
// depends on cpt_pkg; five register stages
module cpt_solve import cpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_dots i_dots,
    output logic  o_valid,
    output t_lane o_lane_s,
    output t_lane o_lane_t,
    output t_meta o_meta
);

    localparam int LoW  = DotW + SplitW + 1;
    localparam int HiW  = DotW + (DotW - SplitW);
    localparam int SumW = ProdW + 1;

    function automatic t_lane mk_lane(logic signed [ProdW-1:0] num,
                                      logic signed [ProdW-1:0] den, logic inv);
        t_lane l;
        l.num = num;
        l.den = den;
        l.inv = inv;
        return l;
    endfunction

    // constant lanes: zero and one come out of the clamp checks
    localparam t_lane LaneZero = '{num: ProdW'(0), den: ProdW'(1), inv: 1'b0};
    localparam t_lane LaneOne  = '{num: ProdW'(1), den: ProdW'(1), inv: 1'b0};

    // stage 4: partial products
    logic signed [DotW-1:0] w_ma[6], w_mb[6];
    logic signed [LoW-1:0]  n_lo[6], r_lo[6];
    logic signed [HiW-1:0]  n_hi[6], r_hi[6];
    t_dots                  r4_dots;
    // stage 5: full products
    logic signed [ProdW-1:0] n_pr[6], r_pr[6];
    t_dots                   r5_dots;
    // stage 6: quadratic terms
    logic signed [ProdW-1:0] r6_det, r6_s0, r6_s1, r6_denom;
    logic signed [ProdW-1:0] r6_t0, r6_t1, r6_u0, r6_u1, r6_num1;
    logic signed [ProdW-1:0] r6_a00, r6_a11, r6_b0, r6_b1;
    // stage 7: decisions and candidate numerators
    logic r7_inside, r7_s0n, r7_s1n, r7_b0n, r7_b1n;
    logic r7_tlt, r7_ult, r7_t1p, r7_u1p, r7_deg;
    logic signed [ProdW-1:0] r7_det, r7_s0, r7_s1, r7_denom, r7_num1;
    logic signed [ProdW-1:0] r7_nb0, r7_nb1, r7_tdiff, r7_udiff, r7_a00, r7_a11;
    // stage 8: lanes
    t_lane      n_ls, n_lt, r_ls, r_lt;
    t_meta      n_meta, r_meta;
    logic [4:0] r_v;

    assign w_ma[0] = i_dots.a00; assign w_mb[0] = i_dots.a11;
    assign w_ma[1] = i_dots.a01; assign w_mb[1] = i_dots.a01;
    assign w_ma[2] = i_dots.a01; assign w_mb[2] = i_dots.b1;
    assign w_ma[3] = i_dots.a11; assign w_mb[3] = i_dots.b0;
    assign w_ma[4] = i_dots.a01; assign w_mb[4] = i_dots.b0;
    assign w_ma[5] = i_dots.a00; assign w_mb[5] = i_dots.b1;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n_lo[j] = LoW'(w_ma[j]) * LoW'($signed({1'b0, w_mb[j][SplitW-1:0]}));
            n_hi[j] = HiW'(w_ma[j]) * HiW'($signed(w_mb[j][DotW-1:SplitW]));
            n_pr[j] = (ProdW'(r_hi[j]) <<< SplitW) + ProdW'(r_lo[j]);
        end
    end

    always_comb begin
        n_ls   = LaneZero;
        n_lt   = LaneZero;
        n_meta.region     = REG_INTERIOR;
        n_meta.degenerate = r7_deg;
        if (r7_inside) begin
            if (r7_s0n) begin
                if (r7_s1n) begin
                    n_meta.region = REG_V0;
                    if (r7_b0n) begin
                        n_ls = mk_lane(r7_nb0, r7_a00, 1'b0);
                    end else if (r7_b1n) begin
                        n_lt = mk_lane(r7_nb1, r7_a11, 1'b0);
                    end
                end else begin
                    n_meta.region = REG_EDGE02;
                    if (r7_b1n) begin
                        n_lt = mk_lane(r7_nb1, r7_a11, 1'b0);
                    end
                end
            end else if (r7_s1n) begin
                n_meta.region = REG_EDGE01;
                if (r7_b0n) begin
                    n_ls = mk_lane(r7_nb0, r7_a00, 1'b0);
                end
            end else begin
                // degenerate interior lands on zero numerators, so both read zero
                n_meta.region = REG_INTERIOR;
                n_ls = mk_lane(r7_s0, r7_det, 1'b0);
                n_lt = mk_lane(r7_s1, r7_det, 1'b0);
            end
        end else if (r7_s0n) begin
            n_meta.region = REG_V2;
            if (r7_tlt) begin
                n_ls = mk_lane(r7_tdiff, r7_denom, 1'b0);
                n_lt = mk_lane(r7_tdiff, r7_denom, 1'b1);
            end else if (!r7_t1p) begin
                n_lt = LaneOne;
            end else if (r7_b1n) begin
                n_lt = mk_lane(r7_nb1, r7_a11, 1'b0);
            end
        end else if (r7_s1n) begin
            n_meta.region = REG_V1;
            if (r7_ult) begin
                n_lt = mk_lane(r7_udiff, r7_denom, 1'b0);
                n_ls = mk_lane(r7_udiff, r7_denom, 1'b1);
            end else if (!r7_u1p) begin
                n_ls = LaneOne;
            end else if (r7_b0n) begin
                n_ls = mk_lane(r7_nb0, r7_a00, 1'b0);
            end
        end else begin
            n_meta.region = REG_EDGE12;
            n_ls = mk_lane(r7_num1, r7_denom, 1'b0);
            n_lt = mk_lane(r7_num1, r7_denom, 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 6; j++) begin
                r_lo[j] <= n_lo[j];
                r_hi[j] <= n_hi[j];
                r_pr[j] <= n_pr[j];
            end
            r4_dots <= i_dots;
            r5_dots <= r4_dots;

            r6_det   <= r_pr[0] - r_pr[1];
            r6_s0    <= r_pr[2] - r_pr[3];
            r6_s1    <= r_pr[4] - r_pr[5];
            r6_denom <= ProdW'(r5_dots.a00) - (ProdW'(r5_dots.a01) <<< 1)
                        + ProdW'(r5_dots.a11);
            r6_t0    <= ProdW'(r5_dots.a01) + ProdW'(r5_dots.b0);
            r6_t1    <= ProdW'(r5_dots.a11) + ProdW'(r5_dots.b1);
            r6_u0    <= ProdW'(r5_dots.a01) + ProdW'(r5_dots.b1);
            r6_u1    <= ProdW'(r5_dots.a00) + ProdW'(r5_dots.b0);
            r6_num1  <= ProdW'(r5_dots.a11) + ProdW'(r5_dots.b1)
                        - ProdW'(r5_dots.a01) - ProdW'(r5_dots.b0);
            r6_a00   <= ProdW'(r5_dots.a00);
            r6_a11   <= ProdW'(r5_dots.a11);
            r6_b0    <= ProdW'(r5_dots.b0);
            r6_b1    <= ProdW'(r5_dots.b1);

            r7_inside <= !(SumW'(r6_det) < (SumW'(r6_s0) + SumW'(r6_s1)));
            r7_s0n    <= r6_s0[ProdW-1];
            r7_s1n    <= r6_s1[ProdW-1];
            r7_b0n    <= r6_b0[ProdW-1];
            r7_b1n    <= r6_b1[ProdW-1];
            r7_tlt    <= r6_t0 < r6_t1;
            r7_ult    <= r6_u0 < r6_u1;
            r7_t1p    <= r6_t1 > ProdW'(0);
            r7_u1p    <= r6_u1 > ProdW'(0);
            r7_deg    <= r6_det == ProdW'(0);
            r7_det    <= r6_det;
            r7_s0     <= r6_s0;
            r7_s1     <= r6_s1;
            r7_denom  <= r6_denom;
            r7_num1   <= r6_num1;
            r7_nb0    <= ProdW'(0) - r6_b0;
            r7_nb1    <= ProdW'(0) - r6_b1;
            r7_tdiff  <= r6_t1 - r6_t0;
            r7_udiff  <= r6_u1 - r6_u0;
            r7_a00    <= r6_a00;
            r7_a11    <= r6_a11;

            r_ls   <= n_ls;
            r_lt   <= n_lt;
            r_meta <= n_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    assign o_valid  = r_v[4];
    assign o_lane_s = r_ls;
    assign o_lane_t = r_lt;
    assign o_meta   = r_meta;

endmodule

// ===== rtl/cpt_div.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage, with clamps
// depends on cpt_pkg
module cpt_div import cpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_lane [1:0]          i_lane,
    input  t_meta                i_meta,
    output logic                 o_valid,
    output logic [1:0][OutW-1:0] o_frac,
    output t_meta                o_meta
);

    typedef struct packed {
        logic [DivW-1:0]  rem;
        logic [DivW-1:0]  den;
        logic [FracW-1:0] q;
        logic             zero;
        logic             one;
        logic             inv;
    } t_dstep;

    t_dstep      n_st[FracW+1][2];
    t_dstep      r_st[FracW+1][2];
    t_meta       r_meta[FracW+1];
    logic [FracW:0] r_v;

    always_comb begin
        logic [DivW-1:0] rem2;
        logic            ge;
        for (int l = 0; l < 2; l++) begin
            n_st[0][l].rem  = DivW'(i_lane[l].num);
            n_st[0][l].den  = DivW'(i_lane[l].den);
            n_st[0][l].q    = '0;
            n_st[0][l].zero = !(i_lane[l].num > ProdW'(0));
            n_st[0][l].one  = !(i_lane[l].num < i_lane[l].den);
            n_st[0][l].inv  = i_lane[l].inv;
        end
        for (int i = 1; i <= FracW; i++) begin
            for (int l = 0; l < 2; l++) begin
                rem2 = r_st[i-1][l].rem << 1;
                ge   = rem2 >= r_st[i-1][l].den;
                n_st[i][l]     = r_st[i-1][l];
                n_st[i][l].rem = ge ? (rem2 - r_st[i-1][l].den) : rem2;
                n_st[i][l].q   = {r_st[i-1][l].q[FracW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i <= FracW; i++) begin
                for (int l = 0; l < 2; l++) begin
                    r_st[i][l] <= n_st[i][l];
                end
            end
            r_meta[0] <= i_meta;
            for (int i = 1; i <= FracW; i++) begin
                r_meta[i] <= r_meta[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[FracW-1:0], i_valid};
        end
    end

    always_comb begin
        logic [OutW-1:0] val;
        for (int l = 0; l < 2; l++) begin
            if (r_st[FracW][l].zero) begin
                val = '0;
            end else if (r_st[FracW][l].one) begin
                val = FxOne;
            end else begin
                val = {1'b0, r_st[FracW][l].q};
            end
            o_frac[l] = r_st[FracW][l].inv ? (FxOne - val) : val;
        end
    end

    assign o_valid = r_v[FracW];
    assign o_meta  = r_meta[FracW];

endmodule

// ===== rtl/closest_point_on_triangle_unit.sv =====
// closest point on a triangle, in reference coordinates: top level
// depends on cpt_pkg, cpt_dot, cpt_solve and cpt_div
//
// takes one query transaction per clock while o_stall is low (a point and three
// vertices) and returns the reference coordinates ref_s, ref_t (unsigned, 16
// fraction bits) of the nearest point on the triangle, the region picked by the
// seven-region test and a flag for a zero determinant. the pipe is made of the
// 16-stage quotient divider (one bit per stage) behind three dot-product stages,
// five stages for the wide products and the region test, the divider's clamp
// stage and the output register. one transaction can enter every cycle while
// o_stall is low. while a finished result is held by i_stall, o_stall is high
// in the same cycle and the whole pipe holds, bubbles included; nothing is
// dropped or repeated
module closest_point_on_triangle_unit import cpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    // pipe advances whenever the output register is free or being drained
    logic                 w_en;
    logic                 w_dot_v;
    t_dots                w_dots;
    logic                 w_sol_v;
    t_lane [1:0]          w_lane;
    t_meta                w_sol_meta;
    logic                 w_div_v;
    logic [1:0][OutW-1:0] w_frac;
    t_meta                w_div_meta;

    t_out_item r_out;
    logic      r_out_v;

    assign w_en    = !r_out_v || !i_stall;
    assign o_stall = !w_en;

    // dot products of the edge and offset vectors
    cpt_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (w_dot_v),
        .o_dots  (w_dots)
    );

    // quadratic terms, region choice, quotient requests
    cpt_solve u_solve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_dot_v),
        .i_dots   (w_dots),
        .o_valid  (w_sol_v),
        .o_lane_s (w_lane[0]),
        .o_lane_t (w_lane[1]),
        .o_meta   (w_sol_meta)
    );

    // lane 0 gives ref_s, lane 1 gives ref_t
    cpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sol_v),
        .i_lane  (w_lane),
        .i_meta  (w_sol_meta),
        .o_valid (w_div_v),
        .o_frac  (w_frac),
        .o_meta  (w_div_meta)
    );

    // output register holds a finished transaction while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.ref_s      <= w_frac[0];
            r_out.ref_t      <= w_frac[1];
            r_out.region     <= w_div_meta.region;
            r_out.degenerate <= w_div_meta.degenerate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_div_v;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

    // a held result must block the input side
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input accepted while result is held");

    // coordinates never exceed one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.ref_s <= FxOne) && (o_item.ref_t <= FxOne))
        else $error("reference coordinate above one");

    // on the far edge the coordinates sum to one
    a_edge12_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.region == REG_EDGE12) |->
        (({1'b0, o_item.ref_s} + {1'b0, o_item.ref_t}) == {1'b0, FxOne}))
        else $error("far edge coordinates do not sum to one");

    // degenerate interior collapses to the first vertex
    a_degen_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.degenerate && o_item.region == REG_INTERIOR) |->
        (o_item.ref_s == '0) && (o_item.ref_t == '0))
        else $error("degenerate interior gave nonzero coordinates");

    // edges through the first vertex pin one coordinate to zero
    a_edge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.region == REG_EDGE02 || o_item.region == REG_EDGE01)) |->
        (o_item.ref_s == '0) || (o_item.ref_t == '0))
        else $error("edge region with both coordinates set");

endmodule
